// ----- rtl/core/pac_pkg.sv -----
// shared types and constants for the polygon area and centroid unit
// no dependencies; compiled before the interfaces and every module

package pac_pkg;

	// default sizes
	localparam int unsigned MAX_VERTICES_DEF = 1024;
	localparam int unsigned COORD_BITS_DEF   = 16;
	localparam int unsigned AREA_BITS_DEF    = 2 * COORD_BITS_DEF + $clog2(MAX_VERTICES_DEF);

	// result status codes, highest priority first in the decision order
	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_FEW  = 2'd1,
		STS_ZERO = 2'd2,
		STS_MANY = 2'd3
	} pac_status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic take;     // vertex word accepted this cycle
		logic close;    // launch the closing edge back to the first vertex
		logic eval;     // latch status and doubled area magnitude
		logic load;     // load the divider for one axis
		logic axis_y;   // axis for load and fin
		logic step;     // one restoring division step
		logic fin;      // saturate the quotient into the centroid register
		logic publish;  // copy the result into the output register and clear
	} pac_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic area_ok;  // polygon is valid and has non-zero area
	} pac_flags_t;

endpackage

// ----- rtl/core/pac_ifs.sv -----
// valid/ready channel interfaces for vertex words and result words
// depends on pac_pkg for the default sizes

interface pac_vertex_if import pac_pkg::*; #(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] vert_x;
	logic signed [COORD_BITS-1:0] vert_y;
	logic                         last_vertex;

	modport source (output valid, vert_x, vert_y, last_vertex, input ready);
	modport sink   (input valid, vert_x, vert_y, last_vertex, output ready);
endinterface

interface pac_result_if import pac_pkg::*; #(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF,
	parameter int unsigned AREA_BITS  = AREA_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic [AREA_BITS-1:0]         area_twice;
	logic signed [COORD_BITS-1:0] centroid_x;
	logic signed [COORD_BITS-1:0] centroid_y;

	modport source (output valid, status, area_twice, centroid_x, centroid_y, input ready);
	modport sink   (input valid, status, area_twice, centroid_x, centroid_y, output ready);
endinterface

// ----- rtl/core/pac_dpath.sv -----
// datapath: edge cross products, running sums, status, shared divider, result register
// depends on pac_pkg; driven by pac_ctrl through pac_cmd_t

module pac_dpath import pac_pkg::*; #(
	parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int unsigned COORD_BITS   = COORD_BITS_DEF,
	localparam int unsigned AREA_W      = 2 * COORD_BITS + $clog2(MAX_VERTICES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pac_cmd_t                     cmd,
	output pac_flags_t                   flags,
	input  logic signed [COORD_BITS-1:0] vert_x,
	input  logic signed [COORD_BITS-1:0] vert_y,
	output logic [1:0]                   status,
	output logic [AREA_W-1:0]            area_twice,
	output logic signed [COORD_BITS-1:0] centroid_x,
	output logic signed [COORD_BITS-1:0] centroid_y
);

	localparam int unsigned LOG_N   = $clog2(MAX_VERTICES);
	localparam int unsigned CNT_W   = $clog2(MAX_VERTICES + 2);
	localparam int unsigned PROD_W  = 2 * COORD_BITS;
	localparam int unsigned EC_W    = 2 * COORD_BITS + 1;
	localparam int unsigned SUM_W   = COORD_BITS + 1;
	localparam int unsigned MP_W    = SUM_W + EC_W;
	localparam int unsigned CROSS_W = AREA_W + 2;
	localparam int unsigned MOM_W   = 3 * COORD_BITS + LOG_N + 2;
	localparam int unsigned DEN_W   = CROSS_W + 2;
	localparam int unsigned DIV_W   = DEN_W + COORD_BITS;
	localparam int unsigned Q_W     = COORD_BITS + 1;

	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_VERTICES);
	localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_VERTICES + 1);
	localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(3);
	localparam logic [Q_W-1:0]   LIM      = Q_W'(1) << (COORD_BITS - 1);
	localparam logic [Q_W-1:0]   LIM_M1   = LIM - Q_W'(1);

	// polygon state
	logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [CNT_W-1:0]             cnt_q;
	logic signed [CROSS_W-1:0]    cross_q;
	logic signed [MOM_W-1:0]      mom_x_q, mom_y_q;

	// edge pipeline
	logic                         v_s1, v_s2;
	logic signed [EC_W-1:0]       c_s1, c_s2;
	logic signed [SUM_W-1:0]      sx_s1, sy_s1;
	logic signed [MP_W-1:0]       mx_s2, my_s2;

	// closing, division and result
	pac_status_t                  sts_q;
	logic [CROSS_W-1:0]           area_q;
	logic [DIV_W-1:0]             rem_q, d_q;
	logic [Q_W-1:0]               q_q;
	logic                         neg_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic [1:0]                   out_sts_q;
	logic [AREA_W-1:0]            out_area_q;
	logic signed [COORD_BITS-1:0] out_cx_q, out_cy_q;

	logic signed [COORD_BITS-1:0] b_x, b_y;
	logic signed [PROD_W-1:0]     p_ab, p_ba;
	logic signed [EC_W-1:0]       c_edge;
	logic signed [SUM_W-1:0]      sx_edge, sy_edge;
	logic                         edge_go;
	logic signed [MP_W-1:0]       mx_nxt, my_nxt;
	pac_status_t                  sts_nxt;
	logic [CROSS_W-1:0]           cross_abs;
	logic [DEN_W-1:0]             den;
	logic signed [MOM_W-1:0]      mom_sel;
	logic [MOM_W-1:0]             mom_abs;
	logic                         ge;
	logic [Q_W-1:0]               q_sat, q_res;

	// edge from the previous vertex to the incoming one, or back to the first
	assign b_x     = cmd.close ? first_x_q : vert_x;
	assign b_y     = cmd.close ? first_y_q : vert_y;
	assign p_ab    = prev_x_q * b_y;
	assign p_ba    = b_x * prev_y_q;
	assign c_edge  = EC_W'(p_ab) - EC_W'(p_ba);
	assign sx_edge = SUM_W'(prev_x_q) + SUM_W'(b_x);
	assign sy_edge = SUM_W'(prev_y_q) + SUM_W'(b_y);
	assign edge_go = (cmd.take && (cnt_q != '0) && (cnt_q < CNT_MAX))
		|| (cmd.close && (cnt_q <= CNT_MAX));

	// stage one valid and stage two valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= edge_go;
			v_s2 <= v_s1;
		end
	end

	// cross term, then moment products
	assign mx_nxt = sx_s1 * c_s1;
	assign my_nxt = sy_s1 * c_s1;

	always_ff @(posedge clk) begin
		c_s1  <= c_edge;
		sx_s1 <= sx_edge;
		sy_s1 <= sy_edge;
		c_s2  <= c_s1;
		mx_s2 <= mx_nxt;
		my_s2 <= my_nxt;
	end

	// first and previous vertex
	always_ff @(posedge clk) begin
		if (cmd.take && (cnt_q < CNT_MAX)) begin
			prev_x_q <= vert_x;
			prev_y_q <= vert_y;
			if (cnt_q == '0) begin
				first_x_q <= vert_x;
				first_y_q <= vert_y;
			end
		end
	end

	// vertex count and running sums, cleared once the result is published
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			cross_q <= '0;
			mom_x_q <= '0;
			mom_y_q <= '0;
		end else if (cmd.publish) begin
			cnt_q   <= '0;
			cross_q <= '0;
			mom_x_q <= '0;
			mom_y_q <= '0;
		end else begin
			if (cmd.take && (cnt_q <= CNT_MAX))
				cnt_q <= cnt_q + CNT_W'(1);
			if (v_s2) begin
				cross_q <= cross_q + CROSS_W'(c_s2);
				mom_x_q <= mom_x_q + MOM_W'(mx_s2);
				mom_y_q <= mom_y_q + MOM_W'(my_s2);
			end
		end
	end

	// status decision
	always_comb begin
		if (cnt_q > CNT_MAX)
			sts_nxt = STS_MANY;
		else if (cnt_q < CNT_MIN)
			sts_nxt = STS_FEW;
		else if (cross_q == '0)
			sts_nxt = STS_ZERO;
		else
			sts_nxt = STS_OK;
	end
	assign flags.area_ok = (sts_nxt == STS_OK);

	// magnitudes and divisor
	assign cross_abs = cross_q[CROSS_W-1] ? CROSS_W'(-cross_q) : CROSS_W'(cross_q);
	assign den       = DEN_W'(area_q) + DEN_W'({area_q, 1'b0});
	assign mom_sel   = cmd.axis_y ? mom_y_q : mom_x_q;
	assign mom_abs   = mom_sel[MOM_W-1] ? MOM_W'(-mom_sel) : MOM_W'(mom_sel);
	assign ge        = (rem_q >= d_q);

	// saturate the quotient to the coordinate range, sign applied last
	always_comb begin
		if (neg_q) begin
			q_sat = (q_q > LIM) ? LIM : q_q;
			q_res = Q_W'(0) - q_sat;
		end else begin
			q_sat = (q_q > LIM_M1) ? LIM_M1 : q_q;
			q_res = q_sat;
		end
	end

	// evaluation, restoring division over COORD_BITS + 1 quotient bits
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			sts_q  <= sts_nxt;
			area_q <= cross_abs;
			cx_q   <= '0;
			cy_q   <= '0;
		end
		if (cmd.load) begin
			d_q   <= {den, {COORD_BITS{1'b0}}};
			rem_q <= DIV_W'(mom_abs);
			neg_q <= mom_sel[MOM_W-1] ^ cross_q[CROSS_W-1];
			q_q   <= '0;
		end else if (cmd.step) begin
			if (ge)
				rem_q <= rem_q - d_q;
			d_q <= d_q >> 1;
			q_q <= {q_q[Q_W-2:0], ge};
		end
		if (cmd.fin) begin
			if (cmd.axis_y)
				cy_q <= q_res[COORD_BITS-1:0];
			else
				cx_q <= q_res[COORD_BITS-1:0];
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_sts_q  <= sts_q;
			out_area_q <= (sts_q == STS_OK) ? area_q[AREA_W-1:0] : '0;
			out_cx_q   <= cx_q;
			out_cy_q   <= cy_q;
		end
	end

	assign status     = out_sts_q;
	assign area_twice = out_area_q;
	assign centroid_x = out_cx_q;
	assign centroid_y = out_cy_q;

`ifndef ASSERT_OFF
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> (!v_s1 && !v_s2))
		else $error("edge pipeline not empty at evaluation");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_OVER)
		else $error("vertex count beyond saturation");

	a_pub_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> (cnt_q == '0))
		else $error("vertex count not cleared after publish");
`endif

endmodule

// ----- rtl/core/pac_ctrl.sv -----
// controller: vertex intake, closing sequence, divider sequencing, output handshake
// depends on pac_pkg; commands pac_dpath through pac_cmd_t

module pac_ctrl import pac_pkg::*; #(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_last,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  pac_flags_t flags,
	output pac_cmd_t   cmd
);

	localparam int unsigned SW = $clog2(COORD_BITS + 1);
	localparam logic [SW-1:0] STEP_LAST = SW'(COORD_BITS);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_CLOSE  = 9'b000000010,
		S_DRAIN1 = 9'b000000100,
		S_DRAIN2 = 9'b000001000,
		S_EVAL   = 9'b000010000,
		S_LOAD   = 9'b000100000,
		S_DIV    = 9'b001000000,
		S_FIN    = 9'b010000000,
		S_PUB    = 9'b100000000
	} pac_state_t;

	pac_state_t    state_q, state_nxt;
	logic          axis_q;
	logic [SW-1:0] step_q;
	logic          out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				cmd.take = in_valid;
				if (in_valid && in_last)
					state_nxt = S_CLOSE;
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				state_nxt = S_DRAIN1;
			end
			S_DRAIN1: begin
				state_nxt = S_DRAIN2;
			end
			S_DRAIN2: begin
				state_nxt = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval  = 1'b1;
				state_nxt = flags.area_ok ? S_LOAD : S_PUB;
			end
			S_LOAD: begin
				cmd.load   = 1'b1;
				cmd.axis_y = axis_q;
				state_nxt  = S_DIV;
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (step_q == STEP_LAST)
					state_nxt = S_FIN;
			end
			S_FIN: begin
				cmd.fin    = 1'b1;
				cmd.axis_y = axis_q;
				state_nxt  = axis_q ? S_PUB : S_LOAD;
			end
			S_PUB: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_nxt   = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state, axis, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.eval)
				axis_q <= 1'b0;
			else if (cmd.fin)
				axis_q <= 1'b1;
			if (cmd.load)
				step_q <= '0;
			else if (cmd.step)
				step_q <= step_q + SW'(1);
			if (cmd.publish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) |=> (state_q == S_CLOSE))
		else $error("last vertex did not start the closing sequence");

	a_pub_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_PUB))
		else $error("result word raised outside the publish state");

	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (step_q <= STEP_LAST))
		else $error("divider step count overran");
`endif

endmodule

// ----- rtl/core/polygon_area_centroid_unit.sv -----
// top level of the polygon doubled area and centroid unit
// depends on pac_pkg, pac_ifs, pac_ctrl and pac_dpath
//
// vtx carries one vertex word per handshake: signed x, y and a last-vertex flag.
// res carries one result word per polygon: status, twice the absolute area and
// the centroid, truncated toward zero and saturated to the coordinate range.
// vertex words are taken one per cycle while the unit is collecting a polygon.
// after the last vertex the closing edge is added, the two-stage multiplier
// pipeline drains and the x then y quotient is found by restoring division,
// COORD_BITS + 1 steps per axis on one shared subtractor.
// a polygon that is flagged in status skips the division and goes straight to publish.
// the next polygon's vertices are taken only once this result is published, and
// that publish waits while the previous result word has not yet been taken.
// the result sits in an output register: while it waits the next polygon is
// taken; only its own publish waits for res.ready.
// reset clears the running sums, vertex count, pipeline valids and res.valid.
// status: 0 ok, 1 fewer than three vertices, 2 zero area, 3 too many vertices;
// area and centroid read zero with any non-zero status.

module polygon_area_centroid_unit import pac_pkg::*; #(
	parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int unsigned COORD_BITS   = COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pac_vertex_if.sink  vtx,
	pac_result_if.source res
);

	pac_cmd_t   cmd;
	pac_flags_t flags;

	// sequencing
	pac_ctrl #(
		.COORD_BITS (COORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vtx.valid),
		.in_last   (vtx.last_vertex),
		.in_ready  (vtx.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	// arithmetic and result register
	pac_dpath #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.flags      (flags),
		.vert_x     (vtx.vert_x),
		.vert_y     (vtx.vert_y),
		.status     (res.status),
		.area_twice (res.area_twice),
		.centroid_x (res.centroid_x),
		.centroid_y (res.centroid_y)
	);

endmodule
